// ===== design/mroc_distance_and_equality_stats_assert.svh =====
// ----------------------------------------------------------------------------
// mROC statistics assertion macros
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MROC_DISTANCE_AND_EQUALITY_STATS_ASSERT_SVH
`define MROC_DISTANCE_AND_EQUALITY_STATS_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent holds -> consequent in the same cycle
`define MROC_AST_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
// antecedent holds -> consequent in the next cycle
`define MROC_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define MROC_AST_NOW(lbl, ante, cons, msg)
`define MROC_AST_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/mroc_des_pkg.sv =====
// ----------------------------------------------------------------------------
// mROC statistics package
// Widths, status codes, divider handshake types and the Q0.16 rounding.
// ----------------------------------------------------------------------------
package mroc_des_pkg;

	localparam int MAX_ITEMS = 1024;
	localparam int PROB_BITS = 16;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int DVS_W     = CNT_W + PROB_BITS;          // n * one fits here
	localparam int FRAC      = 32;
	localparam int POS_W     = FRAC + 1;                   // positions up to 1.0
	localparam int ACC_W     = POS_W + 1;
	localparam int DVD_W     = PROB_BITS + 1 + FRAC;
	localparam int OUT_W     = 17;
	localparam int STAT_W    = 2;
	localparam int MEM_W     = PROB_BITS + 1;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_SINGLE = 2'd1;
	localparam logic [STAT_W-1:0] ST_DROP   = 2'd2;

	localparam logic [OUT_W-1:0] ONE_Q16 = 17'h10000;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DVD_W-1:0]  quotient;
	} div_rsp_t;

	// Q0.32 -> Q0.16, round half up, saturate at one
	function automatic logic [OUT_W-1:0] to_q16(input logic [ACC_W-1:0] v);
		logic [ACC_W:0] r;
		r = ({1'b0, v} + (ACC_W+1)'(32'h8000)) >> 16;
		if (r > (ACC_W+1)'(ONE_Q16))
			return ONE_Q16;
		return r[OUT_W-1:0];
	endfunction

endpackage

// ===== design/mroc_des_if.sv =====
// ----------------------------------------------------------------------------
// mROC statistics channels
// Valid/ready channels for sample beats and result beats.
// ----------------------------------------------------------------------------
interface mroc_des_in_if;
	logic                               valid;
	logic                               ready;
	logic [mroc_des_pkg::PROB_BITS-1:0] probability;
	logic                               outcome;
	logic                               is_last;

	modport source (output valid, probability, outcome, is_last, input ready);
	modport sink   (input valid, probability, outcome, is_last, output ready);
endinterface

interface mroc_des_out_if;
	logic                                valid;
	logic                                ready;
	logic [mroc_des_pkg::OUT_W-1:0]      a_stat;
	logic [mroc_des_pkg::OUT_W-1:0]      b_stat;
	logic [mroc_des_pkg::STAT_W-1:0]     status;

	modport source (output valid, a_stat, b_stat, status, input ready);
	modport sink   (input valid, a_stat, b_stat, status, output ready);
endinterface

// ===== design/mroc_des_ram.sv =====
// ----------------------------------------------------------------------------
// mROC statistics sample RAM
// Single write port, one registered read port.
// ----------------------------------------------------------------------------
module mroc_des_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 17,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== design/mroc_des_div.sv =====
// ----------------------------------------------------------------------------
// mROC statistics divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mroc_des_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mroc_des_pkg::div_req_t req,
	output mroc_des_pkg::div_rsp_t rsp
);
	import mroc_des_pkg::*;

	localparam int ITER_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVD_W-1:0]  quo_q;   // dividend shifts out, quotient shifts in

	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(DVD_W);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

// ===== design/mroc_distance_and_equality_stats.sv =====
// ----------------------------------------------------------------------------
// mROC distance and equality statistics
// Collects probability/outcome samples and reports the A and B statistics.
// ----------------------------------------------------------------------------
// Usage:
//   samples: one beat per sample (probability Q0.16, outcome, is_last).
//     While loading, one beat is taken every cycle and written to the sample
//     RAM in arrival order; beats past capacity are dropped and flagged.
//   results: one beat per data set, after the beat that carries is_last.
//   After the last beat: a divide for A, then, unless only one outcome class
//   is present, two divides for the observed step sizes and a backward walk
//   over the RAM. An observed event takes one RAM read, an observed non-event
//   adds a multiply-accumulate, and an expected step takes up to two serial
//   divides, one RAM read and the multiply-accumulate (PREP, MUL, ACC).
//   The serial divider sets the pace; samples.ready is low during the walk.
//   Reset clears counters and flags; RAM contents are left as they are.
//   A finished result sits in an output register: the next data set loads
//   while it waits. A second result waits in the final state until results
//   is taken.
// ----------------------------------------------------------------------------
module mroc_distance_and_equality_stats (
	input  logic                  clk,
	input  logic                  arst_n,
	mroc_des_in_if.sink           samples,
	mroc_des_out_if.source        results
);
	import mroc_des_pkg::*;

	// sequencer codes
	localparam logic [3:0] S_IDLE  = 4'd0;   // loading samples
	localparam logic [3:0] S_ADIV  = 4'd1;   // A quotient
	localparam logic [3:0] S_N1DIV = 4'd2;   // observed up step
	localparam logic [3:0] S_N0DIV = 4'd3;   // observed right step
	localparam logic [3:0] S_CHK   = 4'd4;   // pick side, issue RAM read
	localparam logic [3:0] S_RD    = 4'd5;   // RAM data back
	localparam logic [3:0] S_D0    = 4'd6;   // expected right step
	localparam logic [3:0] S_D1    = 4'd7;   // expected up step
	localparam logic [3:0] S_PREP  = 4'd8;   // strip width and height
	localparam logic [3:0] S_MUL   = 4'd9;   // low partial product
	localparam logic [3:0] S_ACC   = 4'd10;  // accumulate, advance curve
	localparam logic [3:0] S_FIN   = 4'd11;  // hand result to output reg

	logic [3:0]            state_q;

	// set statistics
	logic [CNT_W-1:0]      cnt_q, ev_q;
	logic [DVS_W-1:0]      sum_q;
	logic                  ovf_q;

	// walk registers
	logic [CNT_W-1:0]      io_q, ie_q;
	logic [POS_W-1:0]      xo_q, xe_q, yo_q, ye_q;
	logic [ACC_W-1:0]      b_q;
	logic [POS_W-1:0]      so0_q, so1_q, st_q, yst_q, w_q, dy_q, a_q;
	logic [2*FRAC-1:0]     prod_s1;
	logic [PROB_BITS-1:0]  p_q;
	logic                  side_q;   // 1: observed curve moves

	// output register
	logic                  out_valid_q;
	logic [OUT_W-1:0]      a_out_q, b_out_q;
	logic [STAT_W-1:0]     status_q;

	div_req_t              div_req_q;
	div_rsp_t              div_rsp;

	// load path
	logic                  accept, keep;
	logic [CNT_W-1:0]      cnt_nx, ev_nx;
	logic [DVS_W-1:0]      sum_nx, ev_one, a_diff, sum_p0;
	logic                  single;
	logic                  sel_obs;
	logic [CNT_W-1:0]      rd_idx;
	logic [ADDR_W-1:0]     raddr;
	logic [MEM_W-1:0]      rdata;
	logic [POS_W-1:0]      gap;
	logic [ACC_W-1:0]      term;
	logic                  out_free;

	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign keep          = cnt_q < CNT_W'(MAX_ITEMS);

	assign cnt_nx = keep ? cnt_q + CNT_W'(1) : cnt_q;
	assign ev_nx  = ev_q + CNT_W'(keep && samples.outcome);
	assign sum_nx = sum_q + (keep ? DVS_W'(samples.probability) : DVS_W'(0));
	assign ev_one = DVS_W'({ev_nx, {PROB_BITS{1'b0}}});
	assign a_diff = (ev_one >= sum_nx) ? ev_one - sum_nx : sum_nx - ev_one;

	assign sum_p0 = DVS_W'({cnt_q, {PROB_BITS{1'b0}}}) - sum_q;
	assign single = (ev_q == '0) || (ev_q == cnt_q);

	// read side picked from positions; index is one below the walk pointer
	assign sel_obs = xo_q < xe_q;
	assign rd_idx  = (sel_obs ? io_q : ie_q) - CNT_W'(1);
	assign raddr   = rd_idx[ADDR_W-1:0];

	assign gap = side_q ? xe_q - xo_q : xo_q - xe_q;

	// floor(dy * w / 2^32) with both below 2^33: high bits as corrections
	assign term = ACC_W'({dy_q[FRAC] & w_q[FRAC], {FRAC{1'b0}}})
	            + (dy_q[FRAC] ? ACC_W'(w_q[FRAC-1:0]) : ACC_W'(0))
	            + (w_q[FRAC]  ? ACC_W'(dy_q[FRAC-1:0]) : ACC_W'(0))
	            + ACC_W'(prod_s1[2*FRAC-1:FRAC]);

	assign out_free = !out_valid_q || results.ready;

	mroc_des_ram #(
		.DEPTH (MAX_ITEMS),
		.WIDTH (MEM_W)
	) u_ram (
		.clk   (clk),
		.we    (accept && keep),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata ({samples.outcome, samples.probability}),
		.raddr (raddr),
		.rdata (rdata)
	);

	mroc_des_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		div_req_t div_nx;
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ev_q        <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			div_req_q   <= '0;
			io_q        <= '0;
			ie_q        <= '0;
			xo_q        <= '0;
			xe_q        <= '0;
			yo_q        <= '0;
			ye_q        <= '0;
			b_q         <= '0;
			side_q      <= 1'b0;
		end else begin
			// start is a one-cycle pulse
			div_nx       = div_req_q;
			div_nx.start = 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= cnt_nx;
						ev_q  <= ev_nx;
						sum_q <= sum_nx;
						if (!keep)
							ovf_q <= 1'b1;
						if (samples.is_last) begin
							div_nx = '{1'b1,
								DVD_W'(a_diff) << (FRAC - PROB_BITS),
								DVS_W'(cnt_nx)};
							state_q <= S_ADIV;
						end
					end
				end
				S_ADIV: begin
					if (div_rsp.done) begin
						io_q <= cnt_q;
						ie_q <= cnt_q;
						xo_q <= '0;
						xe_q <= '0;
						yo_q <= '0;
						ye_q <= '0;
						b_q  <= '0;
						if (single) begin
							state_q <= S_FIN;
						end else begin
							div_nx  = '{1'b1, DVD_W'(1) << FRAC, DVS_W'(ev_q)};
							state_q <= S_N1DIV;
						end
					end
				end
				S_N1DIV: begin
					if (div_rsp.done) begin
						div_nx  = '{1'b1, DVD_W'(1) << FRAC, DVS_W'(cnt_q - ev_q)};
						state_q <= S_N0DIV;
					end
				end
				S_N0DIV: begin
					if (div_rsp.done)
						state_q <= S_CHK;
				end
				S_CHK: begin
					if (io_q == '0 || ie_q == '0) begin
						state_q <= S_FIN;
					end else begin
						side_q  <= sel_obs;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (side_q) begin
						if (rdata[PROB_BITS]) begin
							yo_q    <= yo_q + so1_q;
							io_q    <= io_q - CNT_W'(1);
							state_q <= S_CHK;
						end else begin
							state_q <= S_PREP;
						end
					end else if (sum_p0 != '0) begin
						div_nx = '{1'b1,
							DVD_W'(DVD_W'((PROB_BITS+1)'(1) << PROB_BITS)
								- DVD_W'(rdata[PROB_BITS-1:0])) << FRAC,
							sum_p0};
						state_q <= S_D0;
					end else if (sum_q != '0) begin
						div_nx  = '{1'b1, DVD_W'(rdata[PROB_BITS-1:0]) << FRAC, sum_q};
						state_q <= S_D1;
					end else begin
						state_q <= S_PREP;
					end
				end
				S_D0: begin
					if (div_rsp.done) begin
						if (sum_q != '0) begin
							div_nx  = '{1'b1, DVD_W'(p_q) << FRAC, sum_q};
							state_q <= S_D1;
						end else begin
							state_q <= S_PREP;
						end
					end
				end
				S_D1: begin
					if (div_rsp.done)
						state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					b_q <= b_q + term;
					if (side_q) begin
						xo_q <= xo_q + st_q;
						io_q <= io_q - CNT_W'(1);
					end else begin
						xe_q <= xe_q + st_q;
						ye_q <= ye_q + yst_q;
						ie_q <= ie_q - CNT_W'(1);
					end
					state_q <= S_CHK;
				end
				S_FIN: begin
					if (out_free) begin
						cnt_q       <= '0;
						ev_q        <= '0;
						sum_q       <= '0;
						ovf_q       <= 1'b0;
						io_q        <= '0;
						ie_q        <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			div_req_q   <= div_nx;
			// load on hand-off, drop when taken
			out_valid_q <= (state_q == S_FIN && out_free) || (out_valid_q && !results.ready);
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		prod_s1 <= dy_q[FRAC-1:0] * w_q[FRAC-1:0];
		case (state_q)
			S_ADIV: begin
				if (div_rsp.done)
					a_q <= div_rsp.quotient[POS_W-1:0];
			end
			S_N1DIV: begin
				if (div_rsp.done)
					so1_q <= div_rsp.quotient[POS_W-1:0];
			end
			S_N0DIV: begin
				if (div_rsp.done)
					so0_q <= div_rsp.quotient[POS_W-1:0];
			end
			S_RD: begin
				p_q   <= rdata[PROB_BITS-1:0];
				st_q  <= side_q ? so0_q : '0;
				yst_q <= '0;
			end
			S_D0: begin
				if (div_rsp.done)
					st_q <= div_rsp.quotient[POS_W-1:0];
			end
			S_D1: begin
				if (div_rsp.done)
					yst_q <= div_rsp.quotient[POS_W-1:0];
			end
			S_PREP: begin
				w_q  <= (st_q < gap) ? st_q : gap;
				dy_q <= (yo_q >= ye_q) ? yo_q - ye_q : ye_q - yo_q;
			end
			S_FIN: begin
				if (out_free) begin
					a_out_q <= to_q16(ACC_W'(a_q));
					b_out_q <= single ? '0 : to_q16(b_q);
					if (ovf_q)
						status_q <= ST_DROP;
					else if (single)
						status_q <= ST_SINGLE;
					else
						status_q <= ST_OK;
				end
			end
			default: ;
		endcase
	end

	assign results.valid  = out_valid_q;
	assign results.a_stat = a_out_q;
	assign results.b_stat = b_out_q;
	assign results.status = status_q;

`include "mroc_distance_and_equality_stats_assert.svh"

	// walk pointers never pass the stored count
	`MROC_AST_NOW(a_walk_bound, state_q != S_IDLE, io_q <= cnt_q && ie_q <= cnt_q, "walk pointer past count")
	// divider is never restarted while busy
	`MROC_AST_NOW(a_div_idle, div_req_q.start, !div_rsp.busy, "divider started while busy")
	// the closing beat always starts the A divide
	`MROC_AST_NXT(a_last_start, accept && samples.is_last, state_q == S_ADIV && div_req_q.start, "last beat did not start A")
	// a single-class set reports no area
	`MROC_AST_NOW(a_single_b0, results.valid && results.status == ST_SINGLE, results.b_stat == '0, "single class with nonzero B")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// mROC statistics testbench
// Sends sample beats in data sets, predicts the A/B/status result of every
// set in software, and checks each result beat against the oldest
// prediction. Both channels idle and stall at random, and there is one long
// result hold-off that backs up the sample side.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mroc_des_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		logic [PROB_BITS-1:0] prob;
		logic                 outcome;
		logic                 last;
	} sample_t;

	typedef struct {
		logic [OUT_W-1:0]  a;
		logic [OUT_W-1:0]  b;
		logic [STAT_W-1:0] status;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mroc_des_in_if  samples_if ();
	mroc_des_out_if results_if ();

	mroc_distance_and_equality_stats u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor: its own copy of the sample store and set accumulators
	// ------------------------------------------------------------------
	logic [PROB_BITS-1:0] p_mem [MAX_ITEMS];
	logic                 y_mem [MAX_ITEMS];
	int unsigned          set_len;
	int unsigned          set_events;
	logic [63:0]          set_psum;
	logic                 set_dropped;

	sample_t stim_q[$];
	stats_t  stats_q[$];
	int      mismatches;
	int      samples_taken;

	// floor(a * b / 2^32)
	function automatic logic [63:0] mulq32(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] t;
		t = {64'b0, a} * {64'b0, b};
		return t[95:32];
	endfunction

	function automatic logic [63:0] adiff(input logic [63:0] a, input logic [63:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic logic [OUT_W-1:0] q32_to_q16(input logic [63:0] v);
		logic [63:0] r;
		r = (v + 64'h8000) >> 16;
		return (r > 64'd65536) ? ONE_Q16 : r[OUT_W-1:0];
	endfunction

	// B area: merge observed and expected curves, newest sample first
	function automatic logic [63:0] roc_area(input int unsigned n, input int unsigned n1);
		logic [63:0] xo, xe, yo, ye, acc, st, gap, sp0, p;
		int unsigned io, ie, n0;
		n0 = n - n1;
		sp0 = 64'(n) * 64'd65536 - set_psum;
		xo = 0; xe = 0; yo = 0; ye = 0; acc = 0;
		io = n; ie = n;
		while (io > 0 && ie > 0) begin
			if (xo < xe) begin
				if (y_mem[io-1]) begin
					yo += (64'd1 << 32) / n1;
				end else begin
					st = (64'd1 << 32) / n0;
					gap = xe - xo;
					acc += mulq32(adiff(yo, ye), (st < gap) ? st : gap);
					xo += st;
				end
				io--;
			end else begin
				p = 64'(p_mem[ie-1]);
				st = (sp0 != 0) ? ((64'd65536 - p) << 32) / sp0 : 64'd0;
				gap = xo - xe;
				acc += mulq32(adiff(yo, ye), (st < gap) ? st : gap);
				xe += st;
				if (set_psum != 0)
					ye += (p << 32) / set_psum;
				ie--;
			end
		end
		return acc;
	endfunction

	task automatic predict_sample(input sample_t s);
		stats_t r;
		logic [63:0] a32, b32;
		if (set_len < MAX_ITEMS) begin
			p_mem[set_len] = s.prob;
			y_mem[set_len] = s.outcome;
			set_len++;
			set_events += s.outcome;
			set_psum += 64'(s.prob);
		end else begin
			set_dropped = 1'b1;
		end
		if (s.last) begin
			a32 = (adiff(64'(set_events) * 64'd65536, set_psum) << 16) / set_len;
			b32 = 0;
			if (set_events == 0 || set_events == set_len) begin
				r.status = ST_SINGLE;
			end else begin
				r.status = ST_OK;
				b32 = roc_area(set_len, set_events);
			end
			if (set_dropped)
				r.status = ST_DROP;
			r.a = q32_to_q16(a32);
			r.b = q32_to_q16(b32);
			stats_q.push_back(r);
			set_len = 0;
			set_events = 0;
			set_psum = 0;
			set_dropped = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus: one data set at a time
	// mode 0 uniform, 1 extremes, 2 all zero, 3 single class, 4 small p
	// ------------------------------------------------------------------
	task automatic add_set(input int n, input int mode);
		sample_t s;
		int ev_pct;
		ev_pct = $urandom_range(10, 90);
		for (int i = 0; i < n; i++) begin
			case (mode)
				1: s.prob = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				2: s.prob = '0;
				4: s.prob = PROB_BITS'($urandom_range(0, 300));
				default: s.prob = PROB_BITS'($urandom);
			endcase
			s.outcome = (mode == 3) ? 1'(n & 1) : ($urandom_range(0, 99) < ev_pct);
			s.last = (i == n - 1);
			stim_q.push_back(s);
		end
	endtask

	// ------------------------------------------------------------------
	// Sample driver: fed from stim_q, changes at the falling edge
	// ------------------------------------------------------------------
	logic    in_fire;
	logic    drive_en;
	int      in_gap;
	sample_t cur;

	always @(posedge clk) begin
		in_fire <= samples_if.valid && samples_if.ready;
		if (arst_n && samples_if.valid && samples_if.ready) begin
			cur.prob = samples_if.probability;
			cur.outcome = samples_if.outcome;
			cur.last = samples_if.is_last;
			predict_sample(cur);
			samples_taken++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && drive_en && !(samples_if.valid && !in_fire)) begin
			if (in_gap > 0) begin
				in_gap--;
				samples_if.valid <= 1'b0;
			end else if (stim_q.size() > 0) begin
				cur = stim_q.pop_front();
				samples_if.probability <= cur.prob;
				samples_if.outcome <= cur.outcome;
				samples_if.is_last <= cur.last;
				samples_if.valid <= 1'b1;
				// idle bursts, none near the end of the run
				if (stim_q.size() > 120 && $urandom_range(0, 7) == 0)
					in_gap = $urandom_range(1, 9);
			end else begin
				samples_if.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side: random stalls plus one long hold-off
	// ------------------------------------------------------------------
	int  out_stall;
	int  hold_cycles;
	bit  hold_done;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && samples_taken >= 400) begin
				// long hold-off: results back up and the sample side stalls
				hold_done = 1'b1;
				hold_cycles = 3000;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				results_if.ready <= 1'b0;
			end else if (out_stall > 0) begin
				out_stall--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= 1'b1;
				if (stim_q.size() > 120 && $urandom_range(0, 5) == 0)
					out_stall = $urandom_range(1, 9);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		stats_t e;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (stats_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat a=%0d b=%0d status=%0d",
						results_if.a_stat, results_if.b_stat, results_if.status);
			end else begin
				e = stats_q.pop_front();
				if (results_if.a_stat !== e.a || results_if.b_stat !== e.b ||
						results_if.status !== e.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: exp a=%0d b=%0d st=%0d, got a=%0d b=%0d st=%0d",
							e.a, e.b, e.status, results_if.a_stat,
							results_if.b_stat, results_if.status);
				end
			end
		end
	end

	// cycle limit
	int cycles;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int total;
		samples_if.valid = 1'b0;
		samples_if.probability = '0;
		samples_if.outcome = 1'b0;
		samples_if.is_last = 1'b0;
		results_if.ready = 1'b0;
		in_fire = 1'b0;
		drive_en = 1'b0;
		in_gap = 0;
		out_stall = 0;
		hold_cycles = 0;
		hold_done = 1'b0;
		mismatches = 0;
		samples_taken = 0;
		cycles = 0;
		set_len = 0;
		set_events = 0;
		set_psum = 0;
		set_dropped = 1'b0;

		// directed sets
		add_set(1, 0);                   // one sample: single class
		add_set(4, 1);                   // probability extremes
		add_set(5, 2);                   // zero probability sum
		add_set(4, 3);                   // no events
		add_set(3, 3);                   // all events
		add_set(2, 0);
		begin : extremes
			sample_t s;
			s = '{16'hFFFF, 1'b0, 1'b0}; stim_q.push_back(s);
			s = '{16'h0000, 1'b1, 1'b0}; stim_q.push_back(s);
			s = '{16'h0001, 1'b0, 1'b0}; stim_q.push_back(s);
			s = '{16'h8000, 1'b1, 1'b1}; stim_q.push_back(s);
		end
		// capacity exceeded, mixed classes; a dropped sample closes the set
		add_set(MAX_ITEMS + 3, 0);
		// capacity exceeded, single class
		add_set(MAX_ITEMS + 1, 3);

		// random sets, mostly small
		total = 0;
		while (total < 650) begin
			int n;
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
			add_set(n, $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 4));
			total += n;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		drive_en = 1'b1;

		wait (stim_q.size() == 0 && !samples_if.valid);
		wait (stats_q.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && stats_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/mroc_des_pkg.sv
design/mroc_des_if.sv
design/mroc_des_ram.sv
design/mroc_des_div.sv
design/mroc_distance_and_equality_stats.sv
tb/tb_top.sv
